// ===== rtl/core/prlfc_pkg.sv =====
// Package with the types and constants shared by the page replacement unit.
package prlfc_pkg;

  localparam int FRAMES      = 512;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int FCNT_W      = FRAME_W + 1;
  localparam int PROGRAMS    = 16;
  localparam int PROG_W      = $clog2(PROGRAMS);
  localparam int PAGES       = 1024;
  localparam int PAGE_W      = $clog2(PAGES);
  localparam int SLOT_W      = PROG_W + PAGE_W;
  localparam int MAP_DEPTH   = PROGRAMS * PAGES;
  localparam int MAP_W       = FRAME_W + 1;
  localparam int TIME_W      = 32;
  localparam int FAULT_W     = 32;
  localparam int ADDR_W      = 15;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREPAGE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_LOAD,
    ST_LRU,
    ST_CLK_RD,
    ST_CLK_CHK,
    ST_EVICT_RD,
    ST_EVICT_WR,
    ST_FILL,
    ST_PRE_RD,
    ST_PRE_CHK,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/page_replacement_lru_fifo_clock_top.sv =====
// Top level of the page replacement unit (LRU, FIFO or clock, with prepaging).
//
//  Channel  Direction  Handshake           Payload
//  in_      input      in_tvalid/tready    in_tdata: prog_num, address, last_page
//  out_     output     out_tvalid/tready   out_tdata: hit .. fault_total
//  cfg_     input      cfg_we              cfg_idx, cfg_wdata
//
// A hit reads the page map and the unit is done. A fault takes an empty frame while
// one is left, and prepaging may load the next page too. A fault with all frames in
// use runs a victim search: LRU and FIFO read every timestamp once, the clock sweep
// reads the use bit of each frame it visits, and the eviction reads the old slot and
// clears its map entry. Each state memory has a single read port.
// After reset, and after every write of page_shift, the page map is cleared one
// entry per cycle, all 16384 entries, while in_tready stays low.
// A finished result waits in the output register; the next input is taken
// while it waits, and work stalls only when a second result is ready.
module page_replacement_lru_fifo_clock_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Bits from 0 up: prog_num[3:0], address[18:4], last_page[28:19], zero fill.
  input  logic [prlfc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Bits from 0 up: hit[0], frame[9:1], evicted[10], prepaged[11],
  // prepage_frame[20:12], bad_page[21], fault_total[53:22], zero fill.
  output logic [prlfc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [prlfc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [prlfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int FW = prlfc_pkg::FRAME_W;
  localparam int CW = prlfc_pkg::FCNT_W;
  localparam int SW = prlfc_pkg::SLOT_W;
  localparam int PW = prlfc_pkg::PAGE_W;
  localparam int TW = prlfc_pkg::TIME_W;
  localparam int AW = prlfc_pkg::ADDR_W;

  // State memories: page map (valid plus frame) and the frame table columns.
  logic [prlfc_pkg::MAP_W-1:0] map_mem [prlfc_pkg::MAP_DEPTH];
  logic [SW-1:0]               slot_mem [prlfc_pkg::FRAMES];
  logic [TW-1:0]               time_mem [prlfc_pkg::FRAMES];
  logic                        use_mem  [prlfc_pkg::FRAMES];

  logic                        map_we, map_re;
  logic [SW-1:0]               map_wa, map_ra;
  logic [prlfc_pkg::MAP_W-1:0] map_wd, map_q;
  logic                        fr_we, slot_re, time_re, time_we, use_re, use_we, use_wd;
  logic [FW-1:0]               fr_wa, slot_ra, time_ra, time_wa, use_ra, use_wa;
  logic [SW-1:0]               slot_q;
  logic [TW-1:0]               time_q, time_wd;
  logic                        use_q;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_q <= map_mem[map_ra];
    if (fr_we) slot_mem[fr_wa] <= map_wa;
    if (slot_re) slot_q <= slot_mem[slot_ra];
    if (time_we) time_mem[time_wa] <= time_wd;
    if (time_re) time_q <= time_mem[time_ra];
    if (use_we) use_mem[use_wa] <= use_wd;
    if (use_re) use_q <= use_mem[use_ra];
  end

  prlfc_pkg::state_t state_r, state_nxt;

  logic [1:0]    policy_r, policy_nxt;
  logic          prepage_r, prepage_nxt;
  logic [2:0]    shift_r, shift_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] hand_r, hand_nxt;
  logic [TW-1:0] atime_r, atime_nxt;
  logic [prlfc_pkg::FAULT_W-1:0] fault_r, fault_nxt;

  logic [SW-1:0] slot_r, slot_nxt, tgt_r, tgt_nxt;
  logic [PW-1:0] page_r, page_nxt, last_r, last_nxt;
  logic          is_pre_r, is_pre_nxt, skip_vld_r, skip_vld_nxt;
  logic [FW-1:0] vict_r, vict_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          pend_r, pend_nxt, best_vld_r, best_vld_nxt;
  logic [FW-1:0] pend_idx_r, pend_idx_nxt;
  logic [TW-1:0] best_time_r, best_time_nxt;

  logic          hit_r, hit_nxt, ev_r, ev_nxt, pre_r, pre_nxt, bad_r, bad_nxt, flt_r, flt_nxt;
  logic [FW-1:0] frame_r, frame_nxt, pframe_r, pframe_nxt;

  logic                               out_vld_r, out_vld_nxt;
  logic [prlfc_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // Frames in use for the current page size.
  logic [CW-1:0] n_w;
  assign n_w = CW'(prlfc_pkg::FRAMES >> shift_r);

  // Decode of the incoming access.
  logic [prlfc_pkg::PROG_W-1:0] in_prog;
  logic [AW-1:0]                in_addr, in_addr_m1, in_page;
  logic [PW-1:0]                in_last;
  logic                         in_bad;
  assign in_prog    = in_tdata[3:0];
  assign in_addr    = in_tdata[18:4];
  assign in_last    = in_tdata[28:19];
  assign in_addr_m1 = in_addr - AW'(1);
  assign in_page    = in_addr_m1 >> shift_r;
  assign in_bad     = (in_page > AW'(in_last)) || (in_page >= AW'(prlfc_pkg::PAGES));

  assign in_tready  = (state_r == prlfc_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  logic [FW-1:0] hand_adv;
  assign hand_adv = (CW'(hand_r) + CW'(1) >= n_w) ? '0 : hand_r + FW'(1);

  always_comb begin
    state_nxt     = state_r;
    policy_nxt    = policy_r;
    prepage_nxt   = prepage_r;
    shift_nxt     = shift_r;
    clr_nxt       = clr_r;
    fill_nxt      = fill_r;
    hand_nxt      = hand_r;
    atime_nxt     = atime_r;
    fault_nxt     = fault_r;
    slot_nxt      = slot_r;
    tgt_nxt       = tgt_r;
    page_nxt      = page_r;
    last_nxt      = last_r;
    is_pre_nxt    = is_pre_r;
    skip_vld_nxt  = skip_vld_r;
    vict_nxt      = vict_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    best_vld_nxt  = best_vld_r;
    best_time_nxt = best_time_r;
    hit_nxt       = hit_r;
    ev_nxt        = ev_r;
    pre_nxt       = pre_r;
    bad_nxt       = bad_r;
    flt_nxt       = flt_r;
    frame_nxt     = frame_r;
    pframe_nxt    = pframe_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;

    map_we  = 1'b0;  map_wa  = tgt_r;  map_wd  = '0;
    map_re  = 1'b0;  map_ra  = slot_r;
    fr_we   = 1'b0;  fr_wa   = vict_r;
    slot_re = 1'b0;  slot_ra = vict_r;
    time_re = 1'b0;  time_ra = scan_r[FW-1:0];
    time_we = 1'b0;  time_wa = vict_r;  time_wd = atime_r;
    use_re  = 1'b0;  use_ra  = hand_r;
    use_we  = 1'b0;  use_wa  = vict_r;  use_wd  = policy_r[1];

    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;

    unique case (state_r)
      prlfc_pkg::ST_CLEAR: begin
        map_we  = 1'b1;
        map_wa  = clr_r;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(prlfc_pkg::MAP_DEPTH - 1)) state_nxt = prlfc_pkg::ST_IDLE;
      end
      prlfc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          slot_nxt   = {in_prog, in_page[PW-1:0]};
          page_nxt   = in_page[PW-1:0];
          last_nxt   = in_last;
          hit_nxt    = 1'b0;
          ev_nxt     = 1'b0;
          pre_nxt    = 1'b0;
          flt_nxt    = 1'b0;
          frame_nxt  = '0;
          pframe_nxt = '0;
          bad_nxt    = in_bad;
          map_re     = 1'b1;
          map_ra     = {in_prog, in_page[PW-1:0]};
          state_nxt  = in_bad ? prlfc_pkg::ST_DONE : prlfc_pkg::ST_MAP;
        end
      end
      prlfc_pkg::ST_MAP: begin
        if (map_q[FW]) begin
          hit_nxt   = 1'b1;
          frame_nxt = map_q[FW-1:0];
          // A hit marks the frame as used, or refreshes its time under LRU.
          use_wa    = map_q[FW-1:0];
          use_wd    = 1'b1;
          use_we    = policy_r[1];
          time_wa   = map_q[FW-1:0];
          time_we   = (policy_r == 2'd0);
          state_nxt = prlfc_pkg::ST_DONE;
        end else begin
          flt_nxt      = 1'b1;
          tgt_nxt      = slot_r;
          is_pre_nxt   = 1'b0;
          skip_vld_nxt = 1'b0;
          state_nxt    = prlfc_pkg::ST_LOAD;
        end
      end
      prlfc_pkg::ST_LOAD: begin
        if (fill_r < n_w) begin
          vict_nxt  = fill_r[FW-1:0];
          fill_nxt  = fill_r + CW'(1);
          state_nxt = prlfc_pkg::ST_FILL;
        end else if (policy_r[1]) begin
          if (CW'(hand_r) >= n_w) hand_nxt = '0;
          state_nxt = prlfc_pkg::ST_CLK_RD;
        end else begin
          scan_nxt     = '0;
          best_vld_nxt = 1'b0;
          state_nxt    = prlfc_pkg::ST_LRU;
        end
      end
      prlfc_pkg::ST_LRU: begin
        // One timestamp read issued per cycle, compared in the next cycle.
        if (scan_r < n_w) begin
          time_re      = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[FW-1:0];
          scan_nxt     = scan_r + CW'(1);
        end
        if (pend_r && !(skip_vld_r && pend_idx_r == frame_r) &&
            (!best_vld_r || time_q < best_time_r)) begin
          best_vld_nxt  = 1'b1;
          best_time_nxt = time_q;
          vict_nxt      = pend_idx_r;
        end
        if (scan_r >= n_w && !pend_r) state_nxt = prlfc_pkg::ST_EVICT_RD;
      end
      prlfc_pkg::ST_CLK_RD: begin
        use_re    = 1'b1;
        state_nxt = prlfc_pkg::ST_CLK_CHK;
      end
      prlfc_pkg::ST_CLK_CHK: begin
        if (skip_vld_r && hand_r == frame_r) begin
          hand_nxt  = hand_adv;
          state_nxt = prlfc_pkg::ST_CLK_RD;
        end else if (!use_q) begin
          vict_nxt  = hand_r;
          state_nxt = prlfc_pkg::ST_EVICT_RD;
        end else begin
          use_we    = 1'b1;
          use_wa    = hand_r;
          use_wd    = 1'b0;
          hand_nxt  = hand_adv;
          state_nxt = prlfc_pkg::ST_CLK_RD;
        end
      end
      prlfc_pkg::ST_EVICT_RD: begin
        slot_re   = 1'b1;
        state_nxt = prlfc_pkg::ST_EVICT_WR;
      end
      prlfc_pkg::ST_EVICT_WR: begin
        map_we = 1'b1;
        map_wa = slot_q;
        if (!is_pre_r) ev_nxt = 1'b1;
        state_nxt = prlfc_pkg::ST_FILL;
      end
      prlfc_pkg::ST_FILL: begin
        map_we  = 1'b1;
        map_wd  = {1'b1, vict_r};
        fr_we   = 1'b1;
        time_we = 1'b1;
        use_we  = 1'b1;
        if (is_pre_r) begin
          pframe_nxt = vict_r;
          state_nxt  = prlfc_pkg::ST_DONE;
        end else begin
          frame_nxt = vict_r;
          if (prepage_r && page_r != '1 && (page_r + PW'(1)) <= last_r &&
              (fill_r < n_w || n_w >= CW'(2)))
            state_nxt = prlfc_pkg::ST_PRE_RD;
          else
            state_nxt = prlfc_pkg::ST_DONE;
        end
      end
      prlfc_pkg::ST_PRE_RD: begin
        map_re    = 1'b1;
        map_ra    = slot_r + SW'(1);
        state_nxt = prlfc_pkg::ST_PRE_CHK;
      end
      prlfc_pkg::ST_PRE_CHK: begin
        if (!map_q[FW]) begin
          tgt_nxt      = slot_r + SW'(1);
          is_pre_nxt   = 1'b1;
          skip_vld_nxt = 1'b1;
          pre_nxt      = 1'b1;
          state_nxt    = prlfc_pkg::ST_LOAD;
        end else begin
          state_nxt = prlfc_pkg::ST_DONE;
        end
      end
      prlfc_pkg::ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          logic [prlfc_pkg::FAULT_W-1:0] fcnt;
          fcnt = (flt_r && fault_r != '1) ? fault_r + 32'd1 : fault_r;
          fault_nxt = fcnt;
          if (!bad_r && atime_r != '1) atime_nxt = atime_r + TW'(1);
          out_vld_nxt  = 1'b1;
          out_data_nxt = {2'b00, fcnt, bad_r, pframe_r, pre_r, ev_r, frame_r, hit_r};
          state_nxt    = prlfc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = prlfc_pkg::ST_CLEAR;
    endcase

    // Configuration writes must arrive only while the unit is idle; the block itself does not enforce this.
    if (cfg_we) begin
      unique case (cfg_idx)
        prlfc_pkg::CFG_POLICY:  policy_nxt  = cfg_wdata[1:0];
        prlfc_pkg::CFG_PREPAGE: prepage_nxt = cfg_wdata[0];
        prlfc_pkg::CFG_PAGE_SHIFT: begin
          shift_nxt = cfg_wdata;
          fill_nxt  = '0;
          hand_nxt  = '0;
          clr_nxt   = '0;
          state_nxt = prlfc_pkg::ST_CLEAR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= prlfc_pkg::ST_CLEAR;
      policy_r  <= '0;
      prepage_r <= 1'b0;
      shift_r   <= '0;
      clr_r     <= '0;
      fill_r    <= '0;
      hand_r    <= '0;
      atime_r   <= '0;
      fault_r   <= '0;
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      policy_r  <= policy_nxt;
      prepage_r <= prepage_nxt;
      shift_r   <= shift_nxt;
      clr_r     <= clr_nxt;
      fill_r    <= fill_nxt;
      hand_r    <= hand_nxt;
      atime_r   <= atime_nxt;
      fault_r   <= fault_nxt;
      out_vld_r <= out_vld_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    tgt_r       <= tgt_nxt;
    page_r      <= page_nxt;
    last_r      <= last_nxt;
    is_pre_r    <= is_pre_nxt;
    skip_vld_r  <= skip_vld_nxt;
    vict_r      <= vict_nxt;
    scan_r      <= scan_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_vld_r  <= best_vld_nxt;
    best_time_r <= best_time_nxt;
    hit_r       <= hit_nxt;
    ev_r        <= ev_nxt;
    pre_r       <= pre_nxt;
    bad_r       <= bad_nxt;
    flt_r       <= flt_nxt;
    frame_r     <= frame_nxt;
    pframe_r    <= pframe_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= n_w)
    else $error("fill count exceeds frames in use");
  a_pre_frame: assert property (@(posedge clk) disable iff (!rst_n)
      out_vld_r && out_data_r[11] |-> out_data_r[20:12] != out_data_r[9:1])
    else $error("prepaged page shares the demanded frame");
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
      out_vld_r && out_data_r[21] |-> out_data_r[20:0] == 21'd0)
    else $error("rejected access reports a page result");
`endif

endmodule
